// File: sv/fat12_geometry_sector_map_core_macros.svh
// ----------------------------------------------------------------------------
// FAT12 geometry sector map - assertion macros
// Shared concurrent assertion forms used by the core.
// ----------------------------------------------------------------------------
`ifndef FAT12_GEOMETRY_SECTOR_MAP_CORE_MACROS_SVH
`define FAT12_GEOMETRY_SECTOR_MAP_CORE_MACROS_SVH

// same-cycle implication
`define F12GEO_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define F12GEO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/f12geo_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 geometry sector map - package
// Volume constants, region codes, geometry record and sequencer states.
// ----------------------------------------------------------------------------
package f12geo_pkg;

  localparam int unsigned SECTOR_BYTES     = 512;
  localparam int unsigned ROOT_ENTRIES     = 16;
  localparam int unsigned RESERVED_SECTORS = 1;
  localparam int unsigned DIR_ENTRY_BYTES  = 32;
  localparam int unsigned MAX_CLUSTERS     = 4085;
  localparam int unsigned WORST_FAT        = 12;
  localparam int unsigned ROOT_SECTORS     = ROOT_ENTRIES * DIR_ENTRY_BYTES / SECTOR_BYTES;
  localparam int unsigned SECTOR_SHIFT     = $clog2(SECTOR_BYTES);
  localparam int unsigned PAD_FIXED        = RESERVED_SECTORS + ROOT_SECTORS + WORST_FAT;
  localparam int unsigned MAX_SHIFT        = 12;

  localparam int unsigned SECT_W  = 24;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned SPC_W   = 13;
  localparam int unsigned SPF_W   = 4;
  localparam int unsigned START_W = 5;

  // word index of the single configuration register
  localparam logic CFG_IDX_TARGET = 1'b0;

  typedef enum logic [1:0] {
    REGION_BOOT = 2'd0,
    REGION_FAT  = 2'd1,
    REGION_ROOT = 2'd2,
    REGION_DATA = 2'd3
  } region_e;

  typedef enum logic [2:0] {
    GEO_IDLE,
    GEO_SPC,
    GEO_ROUND,
    GEO_FAT,
    GEO_COMMIT
  } geo_state_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [SPC_W-1:0]   spc;
    logic [SPF_W-1:0]   spf;
    logic [SECT_W-1:0]  total;
    logic [START_W-1:0] dir;
    logic [START_W-1:0] data;
  } geo_t;

  localparam geo_t GEO_RESET = '{
    shift: SHIFT_W'(0),
    spc:   SPC_W'(1),
    spf:   SPF_W'(1),
    total: SECT_W'(0),
    dir:   START_W'(RESERVED_SECTORS + 1),
    data:  START_W'(RESERVED_SECTORS + 1 + ROOT_SECTORS)
  };

endpackage

// File: sv/f12geo_geometry.sv
// ----------------------------------------------------------------------------
// FAT12 geometry sector map - geometry sequencer
// Derives cluster size, FAT size, volume size and region starts from the
// configured byte target after each register write (SPC, ROUND, FAT, COMMIT).
// ----------------------------------------------------------------------------
module f12geo_geometry (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [31:0]         wr_data_i,
  output logic [31:0]         target_o,
  output f12geo_pkg::geo_t    geo_o,
  output logic                busy_o
);
  import f12geo_pkg::*;

  geo_state_e          state_q, state_d;
  logic [31:0]         target_q, target_d;
  logic                zero_q, zero_d;
  logic [SECT_W-1:0]   want_q, want_d;
  logic [SECT_W-1:0]   padded_q, padded_d;
  logic [SHIFT_W-1:0]  shift_q, shift_d;
  logic [SPF_W-1:0]    spf_q, spf_d;
  geo_t                geo_q, geo_d;

  logic [32:0]         round_up;
  logic [SECT_W-1:0]   want_w;
  logic [SECT_W-1:0]   spc_w;
  logic [SECT_W-1:0]   rem_w;
  logic [SPC_W-1:0]    clusters_w;
  logic [15:0]         fat_bytes_w;
  logic [START_W-1:0]  dir_w;

  assign round_up = {1'b0, wr_data_i} + 33'(SECTOR_BYTES - 1);
  assign want_w   = round_up[32:SECTOR_SHIFT];
  assign spc_w    = SECT_W'(1) << shift_q;
  assign rem_w    = want_q & (spc_w - SECT_W'(1));
  assign clusters_w  = SPC_W'(padded_q >> shift_q);
  assign fat_bytes_w = ((16'(clusters_w) + 16'd3) >> 1) * 16'd3;
  assign dir_w    = START_W'(RESERVED_SECTORS) + START_W'(spf_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      GEO_IDLE:   if (wr_en_i) state_d = GEO_SPC;
      GEO_SPC:    state_d = GEO_ROUND;
      GEO_ROUND:  state_d = GEO_FAT;
      GEO_FAT:    state_d = GEO_COMMIT;
      GEO_COMMIT: state_d = GEO_IDLE;
      default:    state_d = GEO_IDLE;
    endcase
    if (wr_en_i) state_d = GEO_SPC;
  end

  always_comb begin
    target_d = target_q;
    zero_d   = zero_q;
    want_d   = want_q;
    padded_d = padded_q;
    shift_d  = shift_q;
    spf_d    = spf_q;
    geo_d    = geo_q;
    if (wr_en_i) begin
      target_d = wr_data_i;
      zero_d   = (wr_data_i == 32'd0);
      want_d   = want_w;
      padded_d = want_w + SECT_W'(PAD_FIXED);
    end else begin
      unique case (state_q)
        GEO_SPC: begin
          for (int k = MAX_SHIFT; k >= 0; k--) begin
            if (padded_q <= SECT_W'(MAX_CLUSTERS << k)) shift_d = SHIFT_W'(k);
          end
        end
        GEO_ROUND: begin
          if (rem_w != '0) padded_d = padded_q + (spc_w - rem_w);
        end
        GEO_FAT: begin
          spf_d = SPF_W'((fat_bytes_w + 16'(SECTOR_BYTES - 1)) >> SECTOR_SHIFT);
        end
        GEO_COMMIT: begin
          if (zero_q) begin
            geo_d = GEO_RESET;
          end else begin
            geo_d.shift = shift_q;
            geo_d.spc   = SPC_W'(1) << shift_q;
            geo_d.spf   = spf_q;
            geo_d.total = padded_q - SECT_W'(WORST_FAT) + SECT_W'(spf_q);
            geo_d.dir   = dir_w;
            geo_d.data  = dir_w + START_W'(ROOT_SECTORS);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= GEO_IDLE;
      target_q <= 32'd0;
      zero_q   <= 1'b1;
      geo_q    <= GEO_RESET;
    end else begin
      state_q  <= state_d;
      target_q <= target_d;
      zero_q   <= zero_d;
      geo_q    <= geo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    want_q   <= want_d;
    padded_q <= padded_d;
    shift_q  <= shift_d;
    spf_q    <= spf_d;
  end

  assign target_o = target_q;
  assign geo_o    = geo_q;
  assign busy_o   = (state_q != GEO_IDLE);

endmodule

// File: sv/fat12_geometry_sector_map_core.sv
// ----------------------------------------------------------------------------
// FAT12 geometry sector map - top level
// Maps logical sectors of a virtual FAT12 volume onto boot, FAT, root
// directory and data regions, with the cluster of each data sector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sector_number per
//   beat; output channel (out_valid_o / out_stall_i) returns one result beat
//   per input beat, in order: region, offset, cluster and current geometry.
//   Each beat passes the input register and then the result register; one
//   beat per cycle is sustained while out_stall_i is low and no update runs.
//   target_bytes is written over the APB-style port; the geometry sequencer
//   then steps through its SPC, ROUND, FAT and COMMIT states, during which
//   in_stall_o is high. A read returns target_bytes.
//   Reset clears both stages and loads the zero-target geometry (one sector
//   per cluster, one FAT sector, zero volume sectors).
//   When out_stall_i holds a result, the input register still takes one more
//   beat; after that in_stall_o rises until the result moves on.
// ----------------------------------------------------------------------------
`include "fat12_geometry_sector_map_core_macros.svh"

module fat12_geometry_sector_map_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sector_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  region_o,
  output logic [31:0] region_index_o,
  output logic [31:0] cluster_number_o,
  output logic [12:0] cluster_sectors_o,
  output logic [3:0]  fat_sectors_o,
  output logic [23:0] volume_sectors_o,
  output logic [3:0]  dir_start_o,
  output logic [3:0]  data_start_o
);
  import f12geo_pkg::*;

  logic        cfg_wr;
  logic        busy;
  logic [31:0] target;
  geo_t        geo;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] sector_q;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  region_q;
  logic [31:0] idx_q;
  logic [31:0] cluster_q;

  logic        advance;
  logic        in_accept;
  region_e     region_w;
  logic [31:0] idx_w;
  logic [31:0] cluster_w;
  logic [31:0] data_off;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_TARGET);

  f12geo_geometry u_geometry (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_wr),
    .wr_data_i (pwdata),
    .target_o  (target),
    .geo_o     (geo),
    .busy_o    (busy)
  );

  assign prdata = target;
  assign pready = 1'b1;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = busy || (s1_valid_q && !advance);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign data_off = sector_q - 32'(geo.data);

  always_comb begin
    region_w  = REGION_DATA;
    idx_w     = data_off;
    cluster_w = (data_off >> geo.shift) + 32'd2;
    if (sector_q < 32'(RESERVED_SECTORS)) begin
      region_w  = REGION_BOOT;
      idx_w     = sector_q;
      cluster_w = '0;
    end else if (sector_q < 32'(geo.dir)) begin
      region_w  = REGION_FAT;
      idx_w     = sector_q - 32'(RESERVED_SECTORS);
      cluster_w = '0;
    end else if (sector_q < 32'(geo.data)) begin
      region_w  = REGION_ROOT;
      idx_w     = sector_q - 32'(geo.dir);
      cluster_w = '0;
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_accept) s1_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) sector_q <= sector_number_i;
    if (advance && s1_valid_q) begin
      region_q  <= region_w;
      idx_q     <= idx_w;
      cluster_q <= cluster_w;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign region_o          = region_q;
  assign region_index_o    = idx_q;
  assign cluster_number_o  = cluster_q;
  assign cluster_sectors_o = geo.spc;
  assign fat_sectors_o     = geo.spf;
  assign volume_sectors_o  = geo.total;
  assign dir_start_o       = geo.dir[3:0];
  assign data_start_o      = geo.data[3:0];

  `F12GEO_ASSERT_IMPL(a_busy_stalls, clk_i, rst_ni, busy, in_stall_o, "beat taken during geometry update")
  `F12GEO_ASSERT_IMPL(a_cluster_zero, clk_i, rst_ni, out_valid_o && (region_o != REGION_DATA), cluster_number_o == 32'd0, "cluster set outside data region")
  `F12GEO_ASSERT_IMPL(a_spc_pow2, clk_i, rst_ni, out_valid_o, $onehot(cluster_sectors_o), "cluster size not a power of two")
  `F12GEO_ASSERT_NEXT(a_cfg_busy, clk_i, rst_ni, cfg_wr, busy, "geometry update not started")

endmodule

// File: test/tb_fat12_geometry_sector_map_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAT12 geometry sector map - testbench
// Programs target_bytes over the APB port across several volume sizes and
// streams sector lookups with random gaps and output stalls. Every result beat
// is checked field by field, in order, against a layout model or typed row.
// ----------------------------------------------------------------------------
module tb_fat12_geometry_sector_map_core;
  import f12geo_pkg::*;

  localparam int unsigned MAX_TARGET  = 32'd4294966784;
  localparam int          PHASES      = 8;
  localparam int          PHASE_BEATS = 145;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          N_DIRECTED  = 24;
  localparam logic [2:0]  TARGET_ADDR = {CFG_IDX_TARGET, 2'b00};

  typedef struct packed {
    logic [12:0] spc;
    logic [3:0]  spf;
    logic [23:0] total;
    logic [3:0]  dir;
    logic [3:0]  data;
  } vol_geom_t;

  typedef struct packed {
    region_e     region;
    logic [31:0] index;
    logic [31:0] cluster;
    logic [12:0] spc;
    logic [3:0]  spf;
    logic [23:0] total;
    logic [3:0]  dir;
    logic [3:0]  data;
  } sector_map_t;

  typedef struct packed {
    bit          is_cfg;
    logic [31:0] value;
    bit          typed;
    sector_map_t want;
  } lookup_row_t;

  localparam sector_map_t UNTYPED = '{REGION_BOOT, 32'd0, 32'd0, 13'd0, 4'd0, 24'd0, 4'd0, 4'd0};

  // rows before the first write run on the zero-target geometry
  localparam lookup_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{1'b0, 32'd0, 1'b1, '{REGION_BOOT, 32'd0, 32'd0, 13'd1, 4'd1, 24'd0, 4'd2, 4'd3}},
    '{1'b0, 32'd1, 1'b1, '{REGION_FAT, 32'd0, 32'd0, 13'd1, 4'd1, 24'd0, 4'd2, 4'd3}},
    '{1'b0, 32'd2, 1'b1, '{REGION_ROOT, 32'd0, 32'd0, 13'd1, 4'd1, 24'd0, 4'd2, 4'd3}},
    '{1'b0, 32'd3, 1'b1, '{REGION_DATA, 32'd0, 32'd2, 13'd1, 4'd1, 24'd0, 4'd2, 4'd3}},
    '{1'b0, 32'hFFFFFFFF, 1'b1,
      '{REGION_DATA, 32'hFFFFFFFC, 32'hFFFFFFFE, 13'd1, 4'd1, 24'd0, 4'd2, 4'd3}},
    '{1'b0, 32'hAAAAAAAA, 1'b0, UNTYPED},
    '{1'b0, 32'h55555555, 1'b0, UNTYPED},
    '{1'b1, MAX_TARGET, 1'b0, UNTYPED},
    '{1'b0, 32'd0, 1'b0, UNTYPED},
    '{1'b0, 32'd7, 1'b0, UNTYPED},
    '{1'b0, 32'd8, 1'b0, UNTYPED},
    '{1'b0, 32'd9, 1'b0, UNTYPED},
    '{1'b0, 32'd4105, 1'b0, UNTYPED},
    '{1'b0, 32'd8388617, 1'b0, UNTYPED},
    '{1'b0, 32'hFFFFFFFF, 1'b0, UNTYPED},
    '{1'b1, 32'd1, 1'b0, UNTYPED},
    '{1'b0, 32'd2, 1'b0, UNTYPED},
    '{1'b0, 32'd4, 1'b0, UNTYPED},
    '{1'b1, 32'd2091520, 1'b0, UNTYPED},
    '{1'b0, 32'd4, 1'b0, UNTYPED},
    '{1'b0, 32'd5, 1'b0, UNTYPED},
    '{1'b0, 32'd6, 1'b0, UNTYPED},
    '{1'b1, 32'd513, 1'b0, UNTYPED},
    '{1'b0, 32'd4, 1'b0, UNTYPED}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] sector_number_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  region_o;
  logic [31:0] region_index_o;
  logic [31:0] cluster_number_o;
  logic [12:0] cluster_sectors_o;
  logic [3:0]  fat_sectors_o;
  logic [23:0] volume_sectors_o;
  logic [3:0]  dir_start_o;
  logic [3:0]  data_start_o;

  sector_map_t pending_maps[$];
  vol_geom_t   layout;
  int          mismatches;
  int          cycle_count;

  fat12_geometry_sector_map_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sector_number_i  (sector_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .region_o         (region_o),
    .region_index_o   (region_index_o),
    .cluster_number_o (cluster_number_o),
    .cluster_sectors_o(cluster_sectors_o),
    .fat_sectors_o    (fat_sectors_o),
    .volume_sectors_o (volume_sectors_o),
    .dir_start_o      (dir_start_o),
    .data_start_o     (data_start_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic vol_geom_t derive_layout(input logic [31:0] target);
    longint unsigned want;
    longint unsigned padded;
    longint unsigned need;
    longint unsigned spc;
    longint unsigned clusters;
    longint unsigned spf;
    longint unsigned total;
    vol_geom_t       g;
    if (target == 32'd0) begin
      spc   = 1;
      spf   = 1;
      total = 0;
    end else begin
      want   = ({32'd0, target} + SECTOR_BYTES - 1) / SECTOR_BYTES;
      padded = want + RESERVED_SECTORS + ROOT_SECTORS + WORST_FAT;
      need   = (padded + MAX_CLUSTERS - 1) / MAX_CLUSTERS;
      spc    = 1;
      while (spc < need) spc = spc << 1;
      if (want % spc != 0) padded = padded + spc - want % spc;
      clusters = padded / spc;
      spf      = ((clusters + 3) / 2 * 3 + SECTOR_BYTES - 1) / SECTOR_BYTES;
      total    = padded - (WORST_FAT - spf);
    end
    g.spc   = spc[12:0];
    g.spf   = spf[3:0];
    g.total = total[23:0];
    g.dir   = 4'(RESERVED_SECTORS + spf);
    g.data  = 4'(RESERVED_SECTORS + spf + ROOT_SECTORS);
    return g;
  endfunction

  function automatic sector_map_t map_sector(input vol_geom_t g, input logic [31:0] s);
    sector_map_t r;
    r.cluster = 32'd0;
    r.spc     = g.spc;
    r.spf     = g.spf;
    r.total   = g.total;
    r.dir     = g.dir;
    r.data    = g.data;
    if (s < RESERVED_SECTORS) begin
      r.region = REGION_BOOT;
      r.index  = s;
    end else if (s < g.dir) begin
      r.region = REGION_FAT;
      r.index  = s - RESERVED_SECTORS;
    end else if (s < g.data) begin
      r.region = REGION_ROOT;
      r.index  = s - g.dir;
    end else begin
      r.region  = REGION_DATA;
      r.index   = s - g.data;
      r.cluster = r.index / g.spc + 32'd2;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    sector_map_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected result beat, region %0d index %0h", $time,
                 region_o, region_index_o);
        mismatches++;
      end else begin
        want = pending_maps.pop_front();
        check_field("region", 32'(want.region), 32'(region_o));
        check_field("region_index", want.index, region_index_o);
        check_field("cluster_number", want.cluster, cluster_number_o);
        check_field("cluster_sectors", 32'(want.spc), 32'(cluster_sectors_o));
        check_field("fat_sectors", 32'(want.spf), 32'(fat_sectors_o));
        check_field("volume_sectors", 32'(want.total), 32'(volume_sectors_o));
        check_field("dir_start", 32'(want.dir), 32'(dir_start_o));
        check_field("data_start", 32'(want.data), 32'(data_start_o));
      end
    end
  end

  // output stall: stretches of none, short and long stalls
  always @(posedge clk_i) begin
    static int stall_mode = 0;
    static int mode_left  = 0;
    static int hold_left  = 0;
    int        pick;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 250);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
    end else if (stall_mode == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        out_stall_i <= 1'b1;
        hold_left = (stall_mode == 2 && $urandom_range(0, 9) == 0) ?
                    $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b0;
        hold_left = $urandom_range(0, 3);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic push_lookup(input logic [31:0] s, input bit typed, input sector_map_t t);
    sector_map_t r;
    r = typed ? t : map_sector(layout, s);
    in_valid_i      <= 1'b1;
    sector_number_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_maps.push_back(r);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    while (pending_maps.size() != 0) @(posedge clk_i);
  endtask

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_target(input logic [31:0] v);
    pause_sender(1);
    wait_results_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TARGET_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    layout = derive_layout(v);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_target();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return $urandom_range(1, 4096);
    if (pick < 50) return $urandom_range(1, 4194304);
    if (pick < 85) return $urandom_range(0, MAX_TARGET);
    return 32'($urandom_range(1, 8388607)) << SECTOR_SHIFT;
  endfunction

  function automatic logic [31:0] pick_sector();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return $urandom_range(0, layout.data + 3);
    if (pick < 55) return 32'(layout.data) + 32'(layout.spc) * $urandom_range(0, 64)
                          + $urandom_range(0, 2) - 32'd1;
    if (pick < 80) return $urandom_range(0, 32'(layout.total) + 16);
    if (pick < 95) return $urandom;
    return 32'hFFFFFFFF - $urandom_range(0, 3);
  endfunction

  initial begin
    logic [31:0] target;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    sector_number_i = '0;
    out_stall_i     = 1'b0;
    mismatches      = 0;
    layout          = derive_layout(32'd0);
    rst_ni          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].is_cfg) begin
        write_target(DIRECTED_ROWS[i].value);
      end else begin
        push_lookup(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        pause_sender(sender_gap());
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) target = 32'd0;
      else if (ph == 1) target = MAX_TARGET;
      else target = pick_target();
      write_target(target);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        push_lookup(pick_sector(), 1'b0, UNTYPED);
        pause_sender(sender_gap());
      end
    end

    pause_sender(1);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_maps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
